/* hw/rtl/swdr_pkg.sv */
// shared types and constants for the sliding window difference run block
package swdr_pkg;

    localparam int NUM_LANES          = 4;
    localparam int DEF_MAX_HALF_WIDTH = 31;
    localparam int DEF_COUNT_BITS     = 16;
    localparam int POS_BITS           = 32;
    localparam int COORD_BITS         = 34;
    localparam int HW_CFG_BITS        = 5;

    localparam logic FUNC_POSITION = 1'b0;
    localparam logic FUNC_FLUSH    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUB,
        S_CMP,
        S_ADD,
        S_ACMP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_ADD,
        LOP_SUB
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     load_prev;
    } lane_ctl_t;

endpackage

/* hw/rtl/swdr_ring.sv */
// ring memory of window entries with registered read
module swdr_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 160
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/swdr_lanes.sv */
// shared per-lane add/subtract unit with running sums and clamped differences
module swdr_lanes #(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 22
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  swdr_pkg::lane_ctl_t                          ctl,
    input  logic [swdr_pkg::NUM_LANES-1:0][COUNT_BITS-1:0] t_in,
    input  logic [swdr_pkg::NUM_LANES-1:0][COUNT_BITS-1:0] c_in,
    output logic [swdr_pkg::NUM_LANES-1:0][SUM_W-1:0]      prev,
    output logic                                         changed,
    output logic                                         prev_any
);
    import swdr_pkg::*;

    logic [NUM_LANES-1:0][SUM_W-1:0] tsum_reg, tsum_next;
    logic [NUM_LANES-1:0][SUM_W-1:0] csum_reg, csum_next;
    logic [NUM_LANES-1:0][SUM_W-1:0] prev_reg, prev_next;
    logic [NUM_LANES-1:0][SUM_W-1:0] diff;

    always_comb begin
        tsum_next = tsum_reg;
        csum_next = csum_reg;
        for (int l = 0; l < NUM_LANES; l++) begin
            case (ctl.op)
                LOP_ADD: begin
                    tsum_next[l] = tsum_reg[l] + SUM_W'(t_in[l]);
                    csum_next[l] = csum_reg[l] + SUM_W'(c_in[l]);
                end
                LOP_SUB: begin
                    tsum_next[l] = tsum_reg[l] - SUM_W'(t_in[l]);
                    csum_next[l] = csum_reg[l] - SUM_W'(c_in[l]);
                end
                default: begin
                end
            endcase
            diff[l] = (tsum_reg[l] > csum_reg[l]) ? tsum_reg[l] - csum_reg[l] : '0;
        end
        prev_next = ctl.load_prev ? diff : prev_reg;
    end

    assign prev     = prev_reg;
    assign changed  = (diff != prev_reg);
    assign prev_any = |prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsum_reg <= '0;
            csum_reg <= '0;
            prev_reg <= '0;
        end else begin
            tsum_reg <= tsum_next;
            csum_reg <= csum_next;
            prev_reg <= prev_next;
        end
    end

endmodule

/* hw/rtl/swdr_clip.sv */
// clips a run to zero and the contig size and drops empty or all-zero runs
module swdr_clip (
    input  logic signed [swdr_pkg::COORD_BITS-1:0] start_in,
    input  logic signed [swdr_pkg::COORD_BITS-1:0] end_in,
    input  logic [swdr_pkg::POS_BITS-1:0]          size,
    input  logic                                   any,
    output logic                                   valid,
    output logic [swdr_pkg::POS_BITS-1:0]          start_out,
    output logic [swdr_pkg::POS_BITS-1:0]          end_out
);
    import swdr_pkg::*;

    logic signed [COORD_BITS-1:0] s;
    logic signed [COORD_BITS-1:0] e;
    logic signed [COORD_BITS-1:0] sz;

    always_comb begin
        s     = start_in;
        e     = end_in;
        sz    = signed'(COORD_BITS'(size));
        valid = any;
        if (s < COORD_BITS'(0)) begin
            if (e > COORD_BITS'(0)) begin
                s = '0;
            end else begin
                valid = 1'b0;
            end
        end
        if (e > sz) begin
            if (s < sz) begin
                e = sz;
            end else begin
                valid = 1'b0;
            end
        end
        start_out = s[POS_BITS-1:0];
        end_out   = e[POS_BITS-1:0];
    end

endmodule

/* hw/rtl/sliding_window_diff_runs.sv */
// top level: sequencer, item latch, run hold and output register
//
//  channel   direction  signals
//  s_        in         s_valid/s_ready, func, position, new_contig, contig_size, counts
//  m_        out        m_valid/m_ready, run_start, run_end, diff_0..3, last_of_run
//  cfg_      in         cfg_wr_en, cfg_wr_data (half width W)
//
// a request steps through idle, then read, subtract and compare per entry it removes,
// read and subtract per entry it keeps, add and compare to add, done to finish; a flush
// has no add; all through the one lane add/subtract unit and the single ring read port
// reset is synchronous, active low; the ring contents are not cleared
// while a run waits in the hold and the output register is full and not taken,
// the sequencer stalls at every compare and at the end
module sliding_window_diff_runs #(
    parameter int MAX_HALF_WIDTH = swdr_pkg::DEF_MAX_HALF_WIDTH,
    parameter int COUNT_BITS     = swdr_pkg::DEF_COUNT_BITS,
    parameter int RING_CAP       = 2 * MAX_HALF_WIDTH + 1,
    parameter int SUM_W          = COUNT_BITS + $clog2(RING_CAP + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [swdr_pkg::HW_CFG_BITS-1:0]   cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [swdr_pkg::POS_BITS-1:0]      s_position,
    input  logic                               s_new_contig,
    input  logic [swdr_pkg::POS_BITS-1:0]      s_contig_size,
    input  logic [COUNT_BITS-1:0]              s_test_count_0,
    input  logic [COUNT_BITS-1:0]              s_test_count_1,
    input  logic [COUNT_BITS-1:0]              s_test_count_2,
    input  logic [COUNT_BITS-1:0]              s_test_count_3,
    input  logic [COUNT_BITS-1:0]              s_control_count_0,
    input  logic [COUNT_BITS-1:0]              s_control_count_1,
    input  logic [COUNT_BITS-1:0]              s_control_count_2,
    input  logic [COUNT_BITS-1:0]              s_control_count_3,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [swdr_pkg::POS_BITS-1:0]      m_run_start,
    output logic [swdr_pkg::POS_BITS-1:0]      m_run_end,
    output logic [SUM_W-1:0]                   m_diff_0,
    output logic [SUM_W-1:0]                   m_diff_1,
    output logic [SUM_W-1:0]                   m_diff_2,
    output logic [SUM_W-1:0]                   m_diff_3,
    output logic                               m_last_of_run
);
    import swdr_pkg::*;

    localparam int DEPTH     = 2 * MAX_HALF_WIDTH + 2;
    localparam int AW        = $clog2(DEPTH);
    localparam int FILL_BITS = $clog2(RING_CAP + 1);
    localparam int HW_BITS   = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CNT_VEC   = NUM_LANES * COUNT_BITS;
    localparam int DW        = POS_BITS + 2 * CNT_VEC;

    state_t state_reg, state_next;

    logic [HW_BITS-1:0]   w_reg;
    logic [31:0]          cfg_ext;
    logic [HW_BITS-1:0]   w_cfg;

    logic                 func_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic                 newc_reg;
    logic [POS_BITS-1:0]  size_in_reg;
    logic [NUM_LANES-1:0][COUNT_BITS-1:0] tcnt_reg, ccnt_reg;
    logic [NUM_LANES-1:0][COUNT_BITS-1:0] tcnt_in, ccnt_in;

    logic [AW-1:0]        head_reg;
    logic [FILL_BITS-1:0] fill_reg;
    logic [POS_BITS-1:0]  size_reg;
    logic signed [COORD_BITS-1:0] pending_reg;
    logic                 forced_reg;
    logic [POS_BITS-1:0]  p_reg;

    logic                 hold_valid_reg;
    logic [POS_BITS-1:0]  hold_start_reg, hold_end_reg;
    logic [NUM_LANES-1:0][SUM_W-1:0] hold_diff_reg;

    logic                 m_valid_reg;
    logic [POS_BITS-1:0]  m_start_reg, m_end_reg;
    logic [NUM_LANES-1:0][SUM_W-1:0] m_diff_reg;
    logic                 m_last_reg;

    logic [DW-1:0]        rd_data;
    logic [AW-1:0]        wr_addr;
    logic [AW:0]          wr_sum;
    logic [POS_BITS-1:0]  rd_pos;
    logic [NUM_LANES-1:0][COUNT_BITS-1:0] rd_t, rd_c;

    logic signed [COORD_BITS-1:0] w_s, pos_s, limit, p_rd_s, p_s, end_sel;
    logic                 is_flush;
    logic                 loop_rm;
    logic                 remove_now;
    logic                 allow;
    logic                 out_free;
    logic                 stall;

    lane_ctl_t            lctl;
    logic [NUM_LANES-1:0][COUNT_BITS-1:0] op_t, op_c;
    logic [NUM_LANES-1:0][SUM_W-1:0] prev;
    logic                 changed, prev_any;

    logic                 clip_valid;
    logic [POS_BITS-1:0]  clip_start, clip_end;

    logic                 accept;
    logic                 do_remove;
    logic                 mem_we;
    logic                 run_take;
    logic                 newc_load;
    logic                 push_out;
    logic                 push_last;

    assign tcnt_in = {s_test_count_3, s_test_count_2, s_test_count_1, s_test_count_0};
    assign ccnt_in = {s_control_count_3, s_control_count_2, s_control_count_1,
                      s_control_count_0};

    // config write, zero taken as one, saturated at the maximum
    assign cfg_ext = 32'(cfg_wr_data);
    assign w_cfg = (cfg_ext == 32'd0) ? HW_BITS'(1) :
                   (cfg_ext > 32'(MAX_HALF_WIDTH)) ? HW_BITS'(MAX_HALF_WIDTH) :
                   HW_BITS'(cfg_ext);

    assign rd_pos = rd_data[DW-1 -: POS_BITS];
    assign rd_t   = rd_data[2*CNT_VEC-1 -: CNT_VEC];
    assign rd_c   = rd_data[CNT_VEC-1:0];
    assign wr_sum = {1'b0, head_reg} + (AW+1)'(fill_reg);
    assign wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : wr_sum[AW-1:0];

    assign w_s    = signed'(COORD_BITS'(w_reg));
    assign pos_s  = signed'(COORD_BITS'(pos_reg));
    assign limit  = pos_s - (w_s <<< 1);
    assign p_rd_s = signed'(COORD_BITS'(rd_pos));
    assign p_s    = signed'(COORD_BITS'(p_reg));
    assign is_flush = (func_reg == FUNC_FLUSH);

    assign loop_rm    = is_flush || newc_reg || (p_rd_s < limit);
    assign remove_now = loop_rm || (fill_reg >= FILL_BITS'(RING_CAP));
    assign allow      = is_flush || newc_reg || (p_s < limit - COORD_BITS'(1));
    assign end_sel    = (state_reg == S_CMP) ? p_s + w_s + COORD_BITS'(1) : pos_s - w_s;
    assign out_free   = !m_valid_reg || m_ready;
    assign stall      = hold_valid_reg && !out_free;
    assign accept     = s_valid && s_ready;

    swdr_ring #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data ({pos_reg, tcnt_reg, ccnt_reg}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    swdr_lanes #(.COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_lanes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lctl),
        .t_in     (op_t),
        .c_in     (op_c),
        .prev     (prev),
        .changed  (changed),
        .prev_any (prev_any)
    );

    swdr_clip u_clip (
        .start_in  (pending_reg),
        .end_in    (end_sel),
        .size      (size_reg),
        .any       (prev_any),
        .valid     (clip_valid),
        .start_out (clip_start),
        .end_out   (clip_end)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (fill_reg != '0) begin
                        state_next = S_READ;
                    end else if (s_func == FUNC_FLUSH) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ADD;
                    end
                end
            end
            S_READ: state_next = S_SUB;
            S_SUB:  state_next = remove_now ? S_CMP : S_ADD;
            S_CMP: begin
                if (!stall) begin
                    if (is_flush) begin
                        state_next = (fill_reg != '0) ? S_READ : S_DONE;
                    end else if (forced_reg) begin
                        state_next = S_ADD;
                    end else begin
                        state_next = (fill_reg != '0) ? S_READ : S_ADD;
                    end
                end
            end
            S_ADD:  state_next = S_ACMP;
            S_ACMP: state_next = stall ? S_ACMP : S_DONE;
            S_DONE: state_next = stall ? S_DONE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        lctl      = '{op: LOP_NONE, load_prev: 1'b0};
        op_t      = rd_t;
        op_c      = rd_c;
        do_remove = 1'b0;
        mem_we    = 1'b0;
        run_take  = 1'b0;
        newc_load = 1'b0;
        push_out  = 1'b0;
        push_last = 1'b0;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_READ: begin
            end
            S_SUB: begin
                if (remove_now) begin
                    lctl.op   = LOP_SUB;
                    do_remove = 1'b1;
                end
            end
            S_CMP: begin
                if (!stall && changed && allow) begin
                    run_take = 1'b1;
                end
            end
            S_ADD: begin
                lctl.op = LOP_ADD;
                op_t    = tcnt_reg;
                op_c    = ccnt_reg;
                mem_we  = 1'b1;
            end
            S_ACMP: begin
                if (!stall) begin
                    if (newc_reg) begin
                        newc_load = 1'b1;
                    end else if (changed) begin
                        run_take = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (hold_valid_reg && out_free) begin
                    push_out  = 1'b1;
                    push_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (run_take || newc_load) begin
            lctl.load_prev = 1'b1;
        end
        if (run_take && clip_valid && hold_valid_reg) begin
            push_out = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            w_reg          <= HW_BITS'(1);
            head_reg       <= '0;
            fill_reg       <= '0;
            size_reg       <= '0;
            pending_reg    <= '1;
            forced_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                w_reg <= w_cfg;
            end
            if (do_remove) begin
                head_reg   <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                fill_reg   <= fill_reg - FILL_BITS'(1);
                forced_reg <= !loop_rm;
            end else if (mem_we) begin
                fill_reg <= fill_reg + FILL_BITS'(1);
            end
            if (run_take) begin
                pending_reg <= end_sel;
            end else if (newc_load) begin
                pending_reg <= pos_s - w_s;
                size_reg    <= size_in_reg;
            end
            if (run_take && clip_valid) begin
                hold_valid_reg <= 1'b1;
            end else if (push_out) begin
                hold_valid_reg <= 1'b0;
            end
            if (push_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg    <= s_func;
            pos_reg     <= s_position;
            newc_reg    <= s_new_contig;
            size_in_reg <= s_contig_size;
            tcnt_reg    <= tcnt_in;
            ccnt_reg    <= ccnt_in;
        end
        if (do_remove) begin
            p_reg <= rd_pos;
        end
        if (run_take && clip_valid) begin
            hold_start_reg <= clip_start;
            hold_end_reg   <= clip_end;
            hold_diff_reg  <= prev;
        end
        if (push_out) begin
            m_start_reg <= hold_start_reg;
            m_end_reg   <= hold_end_reg;
            m_diff_reg  <= hold_diff_reg;
            m_last_reg  <= push_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_run_start   = m_start_reg;
    assign m_run_end     = m_end_reg;
    assign m_diff_0      = m_diff_reg[0];
    assign m_diff_1      = m_diff_reg[1];
    assign m_diff_2      = m_diff_reg[2];
    assign m_diff_3      = m_diff_reg[3];
    assign m_last_of_run = m_last_reg;

    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_BITS'(RING_CAP))
        else $error("ring fill above capacity");

    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("run left in hold at idle");

    a_flush_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && func_reg == FUNC_FLUSH) |-> fill_reg == '0)
        else $error("flush left entries in the window");

endmodule
